// File: rtl/fslc_pkg.sv
// ----------------------------------------------------------------------------
// fslc_pkg
// Shared types, class rules and trapezoid tables of the layer classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fslc_pkg;

  localparam int NF    = 11;  // features
  localparam int NC    = 11;  // classes
  localparam int NT    = 40;  // trapezoid terms over all classes
  localparam int FW    = 17;  // feature width
  localparam int NW    = 16;  // ramp numerator width
  localparam int RW    = 23;  // ramp reciprocal width
  localparam int MW    = 17;  // membership width, 65536 is 1.0
  localparam int NUMW  = 23;  // weighted sum width
  localparam int SCW   = 15;  // unbiased class score width
  localparam int BW    = 17;  // biased score before saturation
  localparam int LW    = 4;   // layer code width
  localparam int CW    = 16;  // configured Q2.14 value width

  localparam logic [LW-1:0] LAYER_NONE = 4'd11;

  // configuration register indexes
  localparam logic [1:0] CFG_BIAS_A   = 2'd0;
  localparam logic [1:0] CFG_BIAS_B   = 2'd1;
  localparam logic [1:0] CFG_BIAS_C   = 2'd2;
  localparam logic [1:0] CFG_MIN_CONF = 2'd3;

  typedef enum logic [1:0] {
    MB_ZERO,
    MB_ONE,
    MB_RAMP
  } mb_mode_e;

  typedef struct packed {
    logic [CW-1:0] score;
    logic [LW-1:0] layer;
  } cand_t;

  // feature: 0 e_low 1 e_mid 2 e_high 3 attack 4 decay 5 centroid
  // 6 flatness 7 zcr 8 harmonicity 9 flux 10 pitch_conf
  localparam int unsigned T_FEAT [NT] = '{
    0, 3, 4, 5,   2, 3, 4, 6,   1, 3, 4, 6,   1, 7,   0, 4, 8,
    4, 9, 8, 10, 1,   3, 4, 8, 9,   4, 9, 6, 3,   9, 3, 4, 5, 8,
    6, 4, 9, 7,   9};
  localparam int unsigned T_CLASS [NT] = '{
    0, 0, 0, 0,   1, 1, 1, 1,   2, 2, 2, 2,   3, 3,   4, 4, 4,
    5, 5, 5, 5, 5,   6, 6, 6, 6,   7, 7, 7, 7,   8, 8, 8, 8, 8,
    9, 9, 9, 9,   10};
  localparam int unsigned T_START [NT] = '{
    19661, 0, 1920, 0,   22938, 0, 0, 16384,   22938, 0, 1280, 9830,
    16384, 6554,   32768, 12800, 26214,
    19200, 0, 32768, 32768, 19661,   0, 3200, 22938, 6554,
    32000, 0, 13107, 3200,   19661, 0, 3200, 9830, 19661,
    26214, 0, 16384, 9830,   13107};
  localparam int unsigned T_PLO [NT] = '{
    36045, 0, 5120, 0,   39322, 0, 0, 29491,   36045, 0, 3840, 19661,
    26214, 13107,   45875, 25600, 39322,
    38400, 0, 45875, 45875, 32768,   0, 6400, 36045, 16384,
    51200, 0, 22938, 7680,   32768, 0, 6400, 19661, 32768,
    39322, 0, 29491, 19661,   26214};
  localparam int unsigned T_PHI [NT] = '{
    65536, 320, 19200, 5243,   65536, 192, 9600, 65536,   65536, 640, 16000, 45875,
    65536, 39322,   65536, 64000, 65536,
    64000, 9830, 65536, 65536, 65536,   640, 22400, 58982, 39322,
    64000, 6554, 45875, 12800,   65536, 960, 25600, 45875, 58982,
    65536, 7680, 65536, 65536,   65536};
  localparam int unsigned T_END [NT] = '{
    65536, 1600, 38400, 13107,   65536, 960, 25600, 65536,   65536, 2560, 32000, 58982,
    65536, 58982,   65536, 64000, 65536,
    64000, 22938, 65536, 65536, 65536,   1920, 38400, 65536, 58982,
    64000, 16384, 58982, 12800,   65536, 3200, 44800, 65536, 65536,
    65536, 19200, 65536, 65536,   65536};
  localparam int unsigned T_WGT [NT] = '{
    35, 30, 20, 15,   35, 20, 20, 25,   30, 25, 25, 20,   60, 40,   40, 30, 30,
    20, 15, 25, 25, 15,   30, 25, 25, 20,   30, 30, 20, 20,   30, 20, 15, 20, 15,
    30, 25, 25, 20,   30};

  localparam int unsigned CL_BASE [NC] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1966080};
  localparam int unsigned CL_DIV  [NC] = '{400, 400, 400, 800, 400, 400, 400, 400, 400, 400,
                                           400};

  // higher score wins, tie keeps the lower class in a
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    r = (b.score > a.score) ? b : a;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/fslc_member.sv
// ----------------------------------------------------------------------------
// fslc_member
// Three-stage trapezoid membership of every term: region, reciprocal
// product, remainder correction.
// ----------------------------------------------------------------------------
`default_nettype none

module fslc_member import fslc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [FW-1:0] feat_i [NF],
  input  logic [NC-1:0] mask_i,
  output logic          valid_o,
  output logic [NC-1:0] mask_o,
  output logic [MW-1:0] memb_o [NT]
);

  logic          va_q, vb_q, vc_q;
  logic [NC-1:0] mask_a_q, mask_b_q, mask_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mask_a_q <= mask_i;
      mask_b_q <= mask_a_q;
      mask_c_q <= mask_b_q;
    end
  end

  assign valid_o = vc_q;
  assign mask_o  = mask_c_q;

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int unsigned DR = T_PLO[j] - T_START[j];
    localparam int unsigned DF = T_END[j] - T_PHI[j];
    localparam longint unsigned RR = (64'd1 << 32) / ((DR == 0) ? 1 : DR);
    localparam longint unsigned RF = (64'd1 << 32) / ((DF == 0) ? 1 : DF);

    logic [FW-1:0]      x;
    mb_mode_e           mode_d, mode_a_q, mode_b_q;
    logic               rise_d, rise_a_q, rise_b_q;
    logic [NW-1:0]      n_d, n_a_q, n_b_q;
    logic [RW-1:0]      r_sel;
    logic [NW+RW-1:0]   prod;
    logic [15:0]        qe_b_q;
    logic [15:0]        den;
    logic [NW+15:0]     nfull, qd, rem;
    logic [MW-1:0]      q, memb_d, memb_q;

    assign x = feat_i[T_FEAT[j]];

    // region of x on the trapezoid; the end points themselves give zero
    always_comb begin
      rise_d = (x < FW'(T_PLO[j]));
      if (x <= FW'(T_START[j]) || x >= FW'(T_END[j])) begin
        mode_d = MB_ZERO;
      end else if (!rise_d && x <= FW'(T_PHI[j])) begin
        mode_d = MB_ONE;
      end else begin
        mode_d = MB_RAMP;
      end
      n_d = rise_d ? NW'(x - FW'(T_START[j])) : NW'(FW'(T_END[j]) - x);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mode_a_q <= mode_d;
        rise_a_q <= rise_d;
        n_a_q    <= n_d;
      end
    end

    // quotient estimate, low by at most one
    assign r_sel = rise_a_q ? RW'(RR) : RW'(RF);
    assign prod  = {{RW{1'b0}}, n_a_q} * {{NW{1'b0}}, r_sel};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mode_b_q <= mode_a_q;
        rise_b_q <= rise_a_q;
        n_b_q    <= n_a_q;
        qe_b_q   <= prod[31:16];
      end
    end

    assign den   = rise_b_q ? 16'(DR) : 16'(DF);
    assign nfull = {n_b_q, 16'b0};
    assign qd    = {16'b0, qe_b_q} * {16'b0, den};
    assign rem   = nfull - qd;
    assign q     = {1'b0, qe_b_q} + MW'(rem >= {16'b0, den});

    always_comb begin
      case (mode_b_q)
        MB_ONE:  memb_d = MW'(65536);
        MB_RAMP: memb_d = q;
        default: memb_d = '0;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        memb_q <= memb_d;
      end
    end

    assign memb_o[j] = memb_q;
  end

endmodule

`default_nettype wire

// File: rtl/fslc_score.sv
// ----------------------------------------------------------------------------
// fslc_score
// Weighted sum, constant divide and bias product of every class.
// ----------------------------------------------------------------------------
`default_nettype none

module fslc_score import fslc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [MW-1:0] memb_i [NT],
  input  logic [NC-1:0] mask_i,
  input  logic [CW-1:0] bias_i [NC],
  output logic          valid_o,
  output logic [BW-1:0] biased_o [NC]
);

  logic          vd_q, ve_q, vf_q, vg_q;
  logic [NC-1:0] mask_d_q, mask_e_q;
  logic [NUMW-1:0] num_d [NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= valid_i;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mask_d_q <= mask_i;
      mask_e_q <= mask_d_q;
    end
  end

  assign valid_o = vg_q;

  // each class adds up at most five terms
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      num_d[k] = NUMW'(CL_BASE[k]);
      for (int j = 0; j < NT; j++) begin
        if (T_CLASS[j] == k) begin
          num_d[k] = num_d[k] + NUMW'(T_WGT[j]) * NUMW'(memb_i[j]);
        end
      end
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_class
    localparam longint unsigned RD = (64'd1 << 24) / CL_DIV[k];

    logic [NUMW-1:0]    num_q, num_e_q, qd, rem;
    logic [NUMW+15:0]   p;
    logic [SCW-1:0]     qe_e_q, sc_d, sc_q;
    logic [SCW+CW-1:0]  bp;
    logic [BW-1:0]      biased_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q <= num_d[k];
      end
    end

    assign p = {16'b0, num_q} * {{NUMW{1'b0}}, 16'(RD)};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_e_q <= num_q;
        qe_e_q  <= p[SCW+23:24];
      end
    end

    // fix the quotient estimate and drop classes not allowed
    assign qd   = NUMW'(qe_e_q) * NUMW'(CL_DIV[k]);
    assign rem  = num_e_q - qd;
    assign sc_d = mask_e_q[k] ? (qe_e_q + SCW'(rem >= NUMW'(CL_DIV[k]))) : '0;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sc_q <= sc_d;
      end
    end

    assign bp = {{CW{1'b0}}, sc_q} * {{SCW{1'b0}}, bias_i[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        biased_q <= bp[BW+13:14];
      end
    end

    assign biased_o[k] = biased_q;
  end

endmodule

`default_nettype wire

// File: rtl/fslc_argmax.sv
// ----------------------------------------------------------------------------
// fslc_argmax
// Saturate the biased scores, pick the best class over a registered tree and
// apply the confidence threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module fslc_argmax import fslc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [BW-1:0] biased_i [NC],
  input  logic [CW-1:0] thr_i,
  output logic          valid_o,
  output logic [LW-1:0] layer_o,
  output logic [CW-1:0] score_o
);

  cand_t leaf [NC];
  cand_t c1_q [6];
  cand_t d0_q, c2c_q;
  cand_t c2a, c2b, c2c, fin;
  logic          vh_q, vi_q, vj_q;
  logic [LW-1:0] layer_q;
  logic [CW-1:0] score_q;

  for (genvar k = 0; k < NC; k++) begin : g_leaf
    assign leaf[k].score = biased_i[k][BW-1:CW] != '0 ? {CW{1'b1}} : biased_i[k][CW-1:0];
    assign leaf[k].layer = LW'(k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
    end else if (en_i) begin
      vh_q <= valid_i;
      vi_q <= vh_q;
      vj_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 5; i++) begin
        c1_q[i] <= pick(leaf[2*i], leaf[2*i+1]);
      end
      c1_q[5] <= leaf[10];
    end
  end

  assign c2a = pick(c1_q[0], c1_q[1]);
  assign c2b = pick(c1_q[2], c1_q[3]);
  assign c2c = pick(c1_q[4], c1_q[5]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d0_q  <= pick(c2a, c2b);
      c2c_q <= c2c;
    end
  end

  assign fin = pick(d0_q, c2c_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      score_q <= fin.score;
      layer_q <= (fin.score == '0 || fin.score < thr_i) ? LAYER_NONE : fin.layer;
    end
  end

  assign valid_o = vj_q;
  assign layer_o = layer_q;
  assign score_o = score_q;

endmodule

`default_nettype wire

// File: rtl/fuzzy_sound_layer_classifier_unit.sv
// ----------------------------------------------------------------------------
// fuzzy_sound_layer_classifier_unit
// Scores one onset's features against eleven layer classes and returns the
// best allowed class that clears the threshold, with its biased Q2.14 score.
// ----------------------------------------------------------------------------
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   in       | in_valid_i / in_stall_o | eleven features, candidate_mask_i
//   out      | out_valid_o/ out_stall_i| layer_o, score_o
//   cfg      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One request per cycle enters unless in_stall_o is high; each one passes
// three membership stages, four score stages and three selection stages.
// Reset clears all stage valid bits and loads the bias and threshold defaults.
// A stalled result freezes every stage at once; in_stall_o follows a waiting
// result that is stalled, so no request is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_sound_layer_classifier_unit import fslc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [16:0]   energy_low_i,
  input  logic [16:0]   energy_mid_i,
  input  logic [16:0]   energy_high_i,
  input  logic [15:0]   attack_time_i,
  input  logic [15:0]   decay_time_i,
  input  logic [16:0]   centroid_i,
  input  logic [16:0]   flatness_i,
  input  logic [16:0]   zero_cross_rate_i,
  input  logic [16:0]   harmonicity_i,
  input  logic [16:0]   flux_i,
  input  logic [16:0]   pitch_confidence_i,
  input  logic [10:0]   candidate_mask_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [3:0]    layer_o,
  output logic [15:0]   score_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [63:0]   cfg_wdata_i
);

  logic          en;
  logic [FW-1:0] feat [NF];
  logic [63:0]   bias_a_q, bias_b_q;
  logic [47:0]   bias_c_q;
  logic [CW-1:0] min_conf_q;
  logic [CW-1:0] bias [NC];
  logic          m_valid, s_valid;
  logic [NC-1:0] m_mask;
  logic [MW-1:0] memb [NT];
  logic [BW-1:0] biased [NC];

  // advance the whole pipeline unless a finished result is held up
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // feature order follows the class rule tables; times widen to 17 bits
  assign feat[0]  = energy_low_i;
  assign feat[1]  = energy_mid_i;
  assign feat[2]  = energy_high_i;
  assign feat[3]  = {1'b0, attack_time_i};
  assign feat[4]  = {1'b0, decay_time_i};
  assign feat[5]  = centroid_i;
  assign feat[6]  = flatness_i;
  assign feat[7]  = zero_cross_rate_i;
  assign feat[8]  = harmonicity_i;
  assign feat[9]  = flux_i;
  assign feat[10] = pitch_confidence_i;

  // configuration registers, bias lanes default to 1.0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_a_q   <= 64'h4000_4000_4000_4000;
      bias_b_q   <= 64'h4000_4000_4000_4000;
      bias_c_q   <= 48'h4000_4000_4000;
      min_conf_q <= 16'd4915;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIAS_A:   bias_a_q   <= cfg_wdata_i;
        CFG_BIAS_B:   bias_b_q   <= cfg_wdata_i;
        CFG_BIAS_C:   bias_c_q   <= cfg_wdata_i[47:0];
        CFG_MIN_CONF: min_conf_q <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // slice the bias groups into one lane per class
  for (genvar k = 0; k < 4; k++) begin : g_bias_ab
    assign bias[k]   = bias_a_q[16*k +: 16];
    assign bias[k+4] = bias_b_q[16*k +: 16];
  end
  for (genvar k = 0; k < 3; k++) begin : g_bias_c
    assign bias[k+8] = bias_c_q[16*k +: 16];
  end

  fslc_member u_member (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .feat_i  (feat),
    .mask_i  (candidate_mask_i),
    .valid_o (m_valid),
    .mask_o  (m_mask),
    .memb_o  (memb)
  );

  fslc_score u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (m_valid),
    .memb_i   (memb),
    .mask_i   (m_mask),
    .bias_i   (bias),
    .valid_o  (s_valid),
    .biased_o (biased)
  );

  fslc_argmax u_argmax (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_valid),
    .biased_i (biased),
    .thr_i    (min_conf_q),
    .valid_o  (out_valid_o),
    .layer_o  (layer_o),
    .score_o  (score_o)
  );

  // a stall toward the source only ever comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a held result");

  a_layer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> layer_o <= LAYER_NONE)
    else $error("layer code out of range");

  a_win_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && layer_o != LAYER_NONE) |-> score_o != '0)
    else $error("class reported with zero score");

endmodule

`default_nettype wire
